>>> rtl/dertlv_pkg.sv
// Package for the DER tag-length-value decoder: item types, element kinds,
// error codes and the tag table. Used by der_tlv_decoder_top; no dependencies.
package dertlv_pkg;

  // Longest long-form length field, in length bytes.
  localparam int unsigned MAX_LENGTH_BYTES = 4;

  // Element kinds, as given by the command field.
  localparam logic [2:0] KIND_BOOL   = 3'd0;
  localparam logic [2:0] KIND_INT    = 3'd1;
  localparam logic [2:0] KIND_BITS   = 3'd2;
  localparam logic [2:0] KIND_OCTETS = 3'd3;
  localparam logic [2:0] KIND_SEQ    = 3'd4;

  // Error codes reported on a result item.
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_TAG   = 3'd1;
  localparam logic [2:0] ERR_BOOL  = 3'd2;
  localparam logic [2:0] ERR_LONG  = 3'd3;
  localparam logic [2:0] ERR_EMPTY = 3'd4;

  // Length field encoding.
  localparam logic [7:0] LEN_LONG_FLAG = 8'h80;
  localparam logic [6:0] LEN_COUNT_MASK = 7'h7f;

  // Decoder phase, one-hot.
  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_LEN_FIRST = 6'b000010,
    PH_LEN_MORE  = 6'b000100,
    PH_BOOL      = 6'b001000,
    PH_UNUSED    = 6'b010000,
    PH_CONTENT   = 6'b100000
  } dertlv_phase_t;

  // One input item: a byte of the DER stream.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
    logic [2:0] command;
  } dertlv_in_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic [31:0] content_length;
    logic [34:0] bit_count;
    logic [2:0]  error_code;
  } dertlv_out_t;

  // Expected tag octet for each element kind.
  function automatic logic [7:0] kind_tag(input logic [2:0] kind);
    logic [7:0] tag;
    unique case (kind)
      KIND_BOOL:   tag = 8'h01;
      KIND_INT:    tag = 8'h02;
      KIND_BITS:   tag = 8'h03;
      KIND_OCTETS: tag = 8'h04;
      KIND_SEQ:    tag = 8'h30;
      default:     tag = 8'h00;
    endcase
    return tag;
  endfunction

endpackage

>>> rtl/der_tlv_decoder_top.sv
// Top level of the DER tag-length-value decoder: state update per byte and a
// two-entry result queue. Depends on dertlv_pkg.
//
// Channel | Handshake                 | Payload
// --------+---------------------------+------------------------------
// data    | data_valid / data_ready   | dertlv_in_t: one stream byte
// res     | res_valid / res_ready     | dertlv_out_t: one result
//
// One byte is taken per cycle while the queue has room; its state update and
// any result are formed in the same cycle and written into the result queue
// at the accept edge. A result appears on res in the cycle after its byte was
// accepted at the earliest, later while older results still wait in the queue.
// data_ready drops only while the two-entry result queue is full, so bytes
// keep flowing while one result waits for res_ready.
// rst is synchronous and active high; it empties the queue and returns the
// decoder to idle.
module der_tlv_decoder_top
  import dertlv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  dertlv_in_t  data,
  output logic        res_valid,
  input  logic        res_ready,
  output dertlv_out_t res
);

  // Decoder state.
  dertlv_phase_t phase, phase_next;
  logic [2:0]    kind, kind_next;
  logic [31:0]   len_acc, len_acc_next;
  logic [31:0]   bytes_rem, bytes_rem_next;
  logic [2:0]    len_left, len_left_next;
  logic [7:0]    pad_bits, pad_bits_next;
  logic          strip_pending, strip_pending_next;

  // Result queue.
  dertlv_out_t   queue [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  logic          accept;
  logic          pop;
  logic          push;
  dertlv_out_t   result;
  logic          len_done;
  logic [31:0]   len_val;
  logic [6:0]    len_count;

  // Bit count of a bit string: eight bits per content byte less the unused
  // bits, floored at zero. Zero for every other kind.
  function automatic logic [34:0] bits_of(input logic [2:0] k, input logic [31:0] len,
                                          input logic [7:0] unused);
    logic [35:0] diff;
    diff = {1'b0, len, 3'b000} - {28'b0, unused};
    if (k != KIND_BITS || diff[35]) begin
      return 35'd0;
    end
    return diff[34:0];
  endfunction

  assign accept     = data_valid && data_ready;
  assign pop        = res_valid && res_ready;
  assign data_ready = (count != 2'd2);
  assign res_valid  = (count != 2'd0);
  assign res        = queue[rd_ptr];
  assign len_count  = data.data_byte[6:0] & LEN_COUNT_MASK;

  // Per-byte state update and result formation.
  always_comb begin
    phase_next         = phase;
    kind_next          = kind;
    len_acc_next       = len_acc;
    bytes_rem_next     = bytes_rem;
    len_left_next      = len_left;
    pad_bits_next      = pad_bits;
    strip_pending_next = strip_pending;
    push               = 1'b0;
    result             = '0;
    len_done           = 1'b0;
    len_val            = 32'd0;

    if (accept) begin
      if (data.start_req) begin
        // A start byte abandons any other element and opens a new one if its tag matches.
        strip_pending_next = 1'b0;
        pad_bits_next      = 8'd0;
        len_acc_next       = 32'd0;
        bytes_rem_next     = 32'd0;
        len_left_next      = 3'd0;
        if (data.command > KIND_SEQ || data.data_byte != kind_tag(data.command)) begin
          push              = 1'b1;
          result.last       = 1'b1;
          result.error_code = ERR_TAG;
        end else begin
          kind_next  = data.command;
          phase_next = PH_LEN_FIRST;
        end
      end else begin
        unique case (phase)
          PH_LEN_FIRST: begin
            if ((data.data_byte & LEN_LONG_FLAG) == 8'd0) begin
              len_done     = 1'b1;
              len_val      = {24'd0, data.data_byte};
              len_acc_next = len_val;
            end else if (len_count > 7'(MAX_LENGTH_BYTES)) begin
              push              = 1'b1;
              result.last       = 1'b1;
              result.error_code = ERR_LONG;
            end else begin
              len_acc_next = 32'd0;
              if (len_count == 7'd0) begin
                len_done = 1'b1;
              end else begin
                len_left_next = len_count[2:0];
                phase_next    = PH_LEN_MORE;
              end
            end
          end
          PH_LEN_MORE: begin
            len_val       = {len_acc[23:0], data.data_byte};
            len_acc_next  = len_val;
            len_left_next = len_left - 3'd1;
            len_done      = (len_left == 3'd1);
          end
          PH_BOOL: begin
            push                  = 1'b1;
            result.out_byte       = {7'd0, (data.data_byte != 8'd0)};
            result.byte_valid     = 1'b1;
            result.last           = 1'b1;
            result.content_length = 32'd1;
          end
          PH_UNUSED: begin
            pad_bits_next = data.data_byte;
            if (bytes_rem == 32'd0) begin
              push        = 1'b1;
              result.last = 1'b1;
            end else begin
              phase_next = PH_CONTENT;
            end
          end
          PH_CONTENT: begin
            strip_pending_next = 1'b0;
            bytes_rem_next     = bytes_rem - 32'd1;
            if (strip_pending && data.data_byte == 8'd0) begin
              // Leading zero byte of a multi-byte integer is dropped.
              len_acc_next = len_acc - 32'd1;
            end else begin
              push                  = 1'b1;
              result.out_byte       = data.data_byte;
              result.byte_valid     = 1'b1;
              result.last           = (bytes_rem == 32'd1);
              result.content_length = len_acc;
              result.bit_count      = bits_of(kind, len_acc, pad_bits);
            end
          end
          PH_IDLE: begin
            // Bytes outside an element are dropped.
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase

        // Length fully decoded: check it against the element kind.
        if (len_done) begin
          case (kind)
            KIND_BOOL: begin
              if (len_val != 32'd1) begin
                push              = 1'b1;
                result.last       = 1'b1;
                result.error_code = ERR_BOOL;
              end else begin
                phase_next = PH_BOOL;
              end
            end
            KIND_BITS: begin
              if (len_val == 32'd0) begin
                push              = 1'b1;
                result.last       = 1'b1;
                result.error_code = ERR_EMPTY;
              end else begin
                len_acc_next   = len_val - 32'd1;
                bytes_rem_next = len_val - 32'd1;
                phase_next     = PH_UNUSED;
              end
            end
            default: begin
              if (len_val == 32'd0) begin
                push        = 1'b1;
                result.last = 1'b1;
              end else begin
                bytes_rem_next     = len_val;
                strip_pending_next = (kind == KIND_INT) && (len_val > 32'd1);
                phase_next         = PH_CONTENT;
              end
            end
          endcase
        end
      end

      // The final result of an element returns the decoder to idle.
      if (push && result.last) begin
        phase_next = PH_IDLE;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      kind          <= KIND_BOOL;
      len_acc       <= 32'd0;
      bytes_rem     <= 32'd0;
      len_left      <= 3'd0;
      pad_bits      <= 8'd0;
      strip_pending <= 1'b0;
    end else begin
      phase         <= phase_next;
      kind          <= kind_next;
      len_acc       <= len_acc_next;
      bytes_rem     <= bytes_rem_next;
      len_left      <= len_left_next;
      pad_bits      <= pad_bits_next;
      strip_pending <= strip_pending_next;
    end
  end

  // Result queue control.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= result;
    end
  end

`ifndef SYNTHESIS
  // The queue never holds more than two results.
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("result queue overflow");

  // Error results end the element and carry no content byte.
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.error_code != ERR_NONE |-> res.last && !res.byte_valid)
    else $error("error result not terminal");

  // A result without a content byte is always the final one of its element.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.byte_valid |-> res.last)
    else $error("non-data result not marked last");

  // A start byte leaves the decoder either in the length phase or idle.
  a_start_phase: assert property (@(posedge clk) disable iff (rst)
    accept && data.start_req |=> phase == PH_LEN_FIRST || phase == PH_IDLE)
    else $error("bad phase after start byte");

  // A pushed result is visible on the output in the next cycle.
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    push |=> res_valid)
    else $error("pushed result not visible");
`endif

endmodule
